>>> design/lpht_pkg.sv
package lpht_pkg;

  // table geometry; the home slot is the low bits of the hash, so the
  // slot count is a power of two
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned PROBE_W     = SLOT_W + 1;
  localparam int unsigned COUNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W     = 11;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VAL_W       = 64;
  localparam int unsigned HALF_W      = KEY_W / 2;

  localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(TABLE_SLOTS - 1);

  // fmix64 constants
  localparam logic [KEY_W-1:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned      FMIX_SHIFT = 33;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FN_PUT    = 2'd0,
    FN_GET    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CK_PUT,
    CK_GET,
    CK_REMOVE,
    CK_CLEAR,
    CK_REFUSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_MIX,
    FE_DONE
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_SWEEP,
    BE_IDLE,
    BE_READ,
    BE_CHECK
  } be_state_t;

endpackage

>>> design/lpht_ram.sv
module lpht_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/lpht_front.sv
module lpht_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  input  logic [63:0]     in_key,
  input  logic [63:0]     in_write_value,
  output logic            push,
  output lpht_pkg::cmd_t  push_cmd,
  input  logic            q_full
);
  import lpht_pkg::*;

  fe_state_t         state_r, state_nxt;
  logic              round_r, round_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [KEY_W-1:0]  x_r, x_nxt;
  logic [KEY_W-1:0]  acc_r, acc_nxt;
  logic [KEY_W-1:0]  prod_r, prod_nxt;
  cmd_t              cmd_r, cmd_nxt;

  logic              accept;
  logic              needs_hash;
  cmd_kind_t         kind_dec;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [KEY_W-1:0]  mul_res;
  logic [KEY_W-1:0]  mul_const;
  logic [KEY_W-1:0]  acc_term;
  logic [KEY_W-1:0]  mixed;

  assign accept = in_valid && in_ready;

  // classify the incoming beat
  always_comb begin
    unique case (func_t'(in_func))
      FN_PUT:    kind_dec = CK_PUT;
      FN_GET:    kind_dec = (in_key == '0) ? CK_REFUSE : CK_GET;
      FN_REMOVE: kind_dec = (in_key == '0) ? CK_REFUSE : CK_REMOVE;
      FN_CLEAR:  kind_dec = CK_CLEAR;
      default:   kind_dec = CK_CLEAR;
    endcase
  end

  assign needs_hash = (kind_dec == CK_PUT) || (kind_dec == CK_GET) ||
                      (kind_dec == CK_REMOVE);

  // shared 32x32 multiplier: lo*lo, lo*hi, hi*lo partial products
  assign mul_const = round_r ? FMIX_C2 : FMIX_C1;
  assign mul_a     = (step_r == 2'd2) ? x_r[KEY_W-1:HALF_W] : x_r[HALF_W-1:0];
  assign mul_b     = (step_r == 2'd1) ? mul_const[KEY_W-1:HALF_W] : mul_const[HALF_W-1:0];
  assign mul_res   = KEY_W'(mul_a) * KEY_W'(mul_b);

  // cross terms only land in the upper half
  assign acc_term = (step_r == 2'd1) ? prod_r : {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
  assign mixed    = acc_r ^ (acc_r >> FMIX_SHIFT);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: if (accept) state_nxt = needs_hash ? FE_MUL : FE_DONE;
      FE_MUL:  if (step_r == 2'd3) state_nxt = FE_MIX;
      FE_MIX:  state_nxt = round_r ? FE_DONE : FE_MUL;
      FE_DONE: if (!q_full) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready  = (state_r == FE_IDLE);
    push      = (state_r == FE_DONE) && !q_full;
    push_cmd  = cmd_r;
    round_nxt = round_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    cmd_nxt   = cmd_r;
    unique case (state_r)
      FE_IDLE: begin
        if (accept) begin
          cmd_nxt.kind  = kind_dec;
          cmd_nxt.key   = in_key;
          cmd_nxt.value = in_write_value;
          cmd_nxt.slot  = '0;
          x_nxt         = in_key ^ (in_key >> FMIX_SHIFT);
          acc_nxt       = '0;
          round_nxt     = 1'b0;
          step_nxt      = 2'd0;
        end
      end
      FE_MUL: begin
        if (step_r != 2'd3) prod_nxt = mul_res;
        if (step_r != 2'd0) acc_nxt = acc_r + acc_term;
        step_nxt = step_r + 2'd1;
      end
      FE_MIX: begin
        x_nxt     = mixed;
        acc_nxt   = '0;
        step_nxt  = 2'd0;
        round_nxt = 1'b1;
        if (round_r) cmd_nxt.slot = mixed[SLOT_W-1:0];
      end
      FE_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    round_r <= round_nxt;
    step_r  <= step_nxt;
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    cmd_r   <= cmd_nxt;
  end

endmodule

>>> design/lpht_queue.sv
module lpht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpht_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output lpht_pkg::cmd_t head_cmd,
  output logic           empty
);
  import lpht_pkg::*;

  cmd_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign head_cmd = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_cmd;
  end

endmodule

>>> design/lpht_back.sv
module lpht_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lpht_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic [63:0]    out_found_value,
  output logic [10:0]    out_entry_count
);
  import lpht_pkg::*;

  be_state_t          state_r, state_nxt;
  logic [SLOT_W-1:0]  addr_r, addr_nxt;
  logic [PROBE_W-1:0] n_r, n_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               report_r, report_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VAL_W-1:0]   out_found_r, out_found_nxt;
  logic [ENTRY_W-1:0] out_count_r, out_count_nxt;

  logic               ram_we;
  logic [KEY_W-1:0]   key_wdata;
  logic [VAL_W-1:0]   val_wdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [VAL_W-1:0]   val_rdata;
  logic               out_free;
  logic               hit;
  logic               empty_slot;
  logic               last_probe;
  logic               last_addr;
  logic [SLOT_W-1:0]  addr_inc;

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (key_wdata),
    .rd_addr (addr_r),
    .rd_data (key_rdata)
  );

  lpht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SLOTS)) u_val_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (val_wdata),
    .rd_addr (addr_r),
    .rd_data (val_rdata)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign pop        = (state_r == BE_IDLE) && !q_empty && out_free;
  assign hit        = (key_rdata == cmd_r.key);
  assign empty_slot = (key_rdata == '0);
  assign last_probe = (n_r == LAST_PROBE);
  assign last_addr  = (addr_r == LAST_SLOT);
  assign addr_inc   = last_addr ? '0 : addr_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_SWEEP: if (last_addr) state_nxt = BE_IDLE;
      BE_IDLE: begin
        if (pop) begin
          unique case (q_cmd.kind)
            CK_CLEAR:  state_nxt = BE_SWEEP;
            CK_REFUSE: state_nxt = BE_IDLE;
            default:   state_nxt = BE_READ;
          endcase
        end
      end
      BE_READ: state_nxt = BE_CHECK;
      BE_CHECK: begin
        unique case (cmd_r.kind)
          CK_PUT:  state_nxt = (hit || empty_slot || last_probe) ? BE_IDLE : BE_READ;
          default: state_nxt = (hit || last_probe) ? BE_IDLE : BE_READ;
        endcase
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  // datapath, memory writes and result loading
  always_comb begin
    addr_nxt       = addr_r;
    n_nxt          = n_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    report_nxt     = report_r;
    ram_we         = 1'b0;
    key_wdata      = '0;
    val_wdata      = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    unique case (state_r)
      BE_SWEEP: begin
        ram_we   = 1'b1;
        addr_nxt = addr_inc;
        if (last_addr) begin
          count_nxt = '0;
          if (report_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_found_nxt  = '0;
            out_count_nxt  = '0;
          end
        end
      end
      BE_IDLE: begin
        if (pop) begin
          cmd_nxt    = q_cmd;
          n_nxt      = '0;
          addr_nxt   = (q_cmd.kind == CK_CLEAR) ? '0 : q_cmd.slot;
          report_nxt = 1'b1;
          if (q_cmd.kind == CK_REFUSE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_found_nxt  = '0;
            out_count_nxt  = ENTRY_W'(count_r);
          end
        end
      end
      BE_READ: begin
      end
      BE_CHECK: begin
        out_found_nxt = '0;
        if (hit || (cmd_r.kind == CK_PUT && empty_slot) || last_probe) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          unique case (cmd_r.kind)
            CK_PUT: begin
              if (hit) begin
                out_status_nxt = ST_DUP;
              end else if (empty_slot) begin
                ram_we    = 1'b1;
                key_wdata = cmd_r.key;
                val_wdata = cmd_r.value;
                count_nxt = count_r + 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            CK_GET: begin
              if (hit) out_found_nxt = val_rdata;
              else out_status_nxt = ST_MISS;
            end
            default: begin
              // remove clears the slot
              if (hit) begin
                ram_we = 1'b1;
                if (count_r != '0) count_nxt = count_r - 1'b1;
              end else begin
                out_status_nxt = ST_MISS;
              end
            end
          endcase
          out_count_nxt = ENTRY_W'(count_nxt);
        end else begin
          n_nxt    = n_r + 1'b1;
          addr_nxt = addr_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_entry_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_SWEEP;
      addr_r      <= '0;
      count_r     <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      count_r     <= count_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    cmd_r        <= cmd_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

>>> design/linear_probe_hash_table.sv
// Key/value table of 64-bit keys and values, open addressing, linear probing.
// Input channel in_*: one beat carries func (put, get, remove, clear), key and
// write_value. Output channel out_*: one beat per input beat, in order, with
// status, found_value and entry_count after the operation.
// The front hashes the key of each put, get or remove with fmix64 on one
// shared 32x32 multiplier, then pushes the command into a two-entry queue;
// the front takes its next beat only after that push. The back takes a
// command off the queue in its idle state, then probes the key and value
// memories slot by slot, each probe a registered memory read and then a
// compare; the output register loads on the last compare.
// A get or remove that misses scans all TABLE_SLOTS slots. Get or remove of
// key zero skips the hash and is answered at the edge it leaves the queue.
// Clear writes zeros over every slot of both memories, one slot a cycle.
// Reset runs the same clearing pass; beats may be taken meanwhile, up to
// what the front and queue hold, and results follow once the pass is done.
// When the receiver stalls the result holds in the output register and the
// back waits; the front and queue keep taking beats until the queue fills.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [63:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_value,
  output logic [10:0] out_entry_count
);
  import lpht_pkg::*;

  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // hash and classify
  lpht_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .push           (q_push),
    .push_cmd       (q_push_cmd),
    .q_full         (q_full)
  );

  // command queue
  lpht_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head),
    .empty    (q_empty)
  );

  // probe, update and respond
  lpht_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

  // front never writes into a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full command queue");

  // back never takes from an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");

  // front holds one beat at a time while hashing
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front took a beat while hashing");

  // a value is returned only by a successful lookup
  a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_found_value == '0))
    else $error("found value on a failed operation");

endmodule
